@@ rtl/core/irnf_pkg.sv @@
package irnf_pkg;

    localparam int DIM_BITS     = 6;
    localparam int MAX_DIM      = 64;
    localparam int DIMW_BITS    = DIM_BITS + 1;
    localparam int ADDR_BITS    = 2 * DIM_BITS;
    localparam int PIX_BITS     = 8;
    localparam int COEF_BITS    = 16;
    localparam int FRAC_BITS    = 14;
    localparam int PROD_BITS    = DIMW_BITS + COEF_BITS;
    localparam int SUM_BITS     = PROD_BITS + 2;
    localparam int RND_BITS     = SUM_BITS - FRAC_BITS;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_BITS     = 16;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_W   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_H   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COS      = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SIN      = 3'd5;

    typedef struct packed {
        logic [1:0]          kind;
        logic [DIM_BITS-1:0] pos_x;
        logic [DIM_BITS-1:0] pos_y;
        logic [PIX_BITS-1:0] pixel_in;
    } t_item;

    typedef struct packed {
        logic [PIX_BITS-1:0] pixel_out;
        logic                landed;
        logic [DIM_BITS-1:0] dest_x;
        logic [DIM_BITS-1:0] dest_y;
    } t_result;

    typedef struct packed {
        logic                 we;
        logic                 re;
        logic [ADDR_BITS-1:0] addr;
        logic [PIX_BITS-1:0]  wdata;
    } t_store_req;

endpackage

@@ rtl/core/irnf_store.sv @@
module irnf_store (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start_clear,
    input  irnf_pkg::t_store_req         i_req,
    output logic [irnf_pkg::PIX_BITS-1:0] o_rdata,
    output logic                         o_clearing
);
    import irnf_pkg::*;

    logic [PIX_BITS-1:0]  r_mem [2**ADDR_BITS];
    logic [PIX_BITS-1:0]  r_rdata;
    logic                 r_clearing;
    logic [ADDR_BITS-1:0] r_idx;

    logic                 w_we;
    logic [ADDR_BITS-1:0] w_waddr;
    logic [PIX_BITS-1:0]  w_wdata;

    // sweep has the write port to itself; the pipeline is drained while it runs
    always_comb begin
        if (r_clearing) begin
            w_we    = 1'b1;
            w_waddr = r_idx;
            w_wdata = '0;
        end else begin
            w_we    = i_req.we;
            w_waddr = i_req.addr;
            w_wdata = i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_idx      <= '0;
        end else if (i_start_clear) begin
            r_clearing <= 1'b1;
            r_idx      <= '0;
        end else if (r_clearing) begin
            r_idx <= r_idx + 1'b1;
            if (r_idx == {ADDR_BITS{1'b1}}) begin
                r_clearing <= 1'b0;
            end
        end
    end

    assign o_rdata    = r_rdata;
    assign o_clearing = r_clearing;

endmodule

@@ rtl/core/image_rotate_nearest_forward_unit.sv @@
// Nearest-neighbor image rotation, forward mapped, into a 64x64 pixel store.
// Items enter on start/i_item when busy is low: kind 0 maps a source pixel
// and stores it at its rotated spot, kind 1 reads one stored pixel, kind 2
// zeroes the whole store. Every item gives exactly one beat on
// o_strobe/o_result, registered through each pipeline stage in turn;
// o_strobe is the last stage's valid, and no stall can hold an item back.
// Writes and reads enter one per cycle while busy is low; the pipeline is
// two compute stages (multiply-add, then round/bounds check) and the store
// access. A clear item holds busy while it drains the pipeline and then
// for the sweep of all 4096 store entries, one entry a cycle through its
// write port. After reset the same sweep runs, so busy stays high until it ends.
// The configuration port (i_cfg_we/i_cfg_idx/i_cfg_data) writes at once,
// and is only meant to be used while no item is in flight.
// o_strobe is high for a single cycle per beat; the receiver cannot stall,
// so nothing is held back on the output side.
module image_rotate_nearest_forward_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  irnf_pkg::t_item                      i_item,
    output logic                                 o_strobe,
    output irnf_pkg::t_result                    o_result,
    input  logic                                 i_cfg_we,
    input  logic [irnf_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [irnf_pkg::CFG_BITS-1:0]        i_cfg_data
);
    import irnf_pkg::*;

    // configuration
    logic [DIMW_BITS-1:0]        r_grid_w;
    logic [DIMW_BITS-1:0]        r_grid_h;
    logic [DIM_BITS-1:0]         r_cx;
    logic [DIM_BITS-1:0]         r_cy;
    logic signed [COEF_BITS-1:0] r_cos;
    logic signed [COEF_BITS-1:0] r_sin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w <= DIMW_BITS'(MAX_DIM);
            r_grid_h <= DIMW_BITS'(MAX_DIM);
            r_cx     <= '0;
            r_cy     <= '0;
            r_cos    <= COEF_BITS'(1 << FRAC_BITS);
            r_sin    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GRID_W:   r_grid_w <= i_cfg_data[DIMW_BITS-1:0];
                CFG_GRID_H:   r_grid_h <= i_cfg_data[DIMW_BITS-1:0];
                CFG_CENTER_X: r_cx     <= i_cfg_data[DIM_BITS-1:0];
                CFG_CENTER_Y: r_cy     <= i_cfg_data[DIM_BITS-1:0];
                CFG_COS:      r_cos    <= i_cfg_data[COEF_BITS-1:0];
                CFG_SIN:      r_sin    <= i_cfg_data[COEF_BITS-1:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, anything above the store size as the store size
    logic [DIMW_BITS-1:0] w_eff_w;
    logic [DIMW_BITS-1:0] w_eff_h;

    always_comb begin
        if (r_grid_w == '0) begin
            w_eff_w = DIMW_BITS'(1);
        end else if (r_grid_w > DIMW_BITS'(MAX_DIM)) begin
            w_eff_w = DIMW_BITS'(MAX_DIM);
        end else begin
            w_eff_w = r_grid_w;
        end
        if (r_grid_h == '0) begin
            w_eff_h = DIMW_BITS'(1);
        end else if (r_grid_h > DIMW_BITS'(MAX_DIM)) begin
            w_eff_h = DIMW_BITS'(MAX_DIM);
        end else begin
            w_eff_h = r_grid_h;
        end
    end

    logic w_accept;
    assign w_accept = start && !busy;

    // stage 1: captured item
    logic                r_s1_valid;
    logic [1:0]          r_s1_kind;
    logic                r_s1_in_ok;
    logic [DIM_BITS-1:0] r_s1_px;
    logic [DIM_BITS-1:0] r_s1_py;
    logic [PIX_BITS-1:0] r_s1_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_kind  <= i_item.kind;
            r_s1_in_ok <= ({1'b0, i_item.pos_x} < w_eff_w) && ({1'b0, i_item.pos_y} < w_eff_h);
            r_s1_px    <= i_item.pos_x;
            r_s1_py    <= i_item.pos_y;
            r_s1_pix   <= i_item.pixel_in;
        end
    end

    // offsets from the center times the coefficients
    logic signed [DIMW_BITS-1:0] w_dx;
    logic signed [DIMW_BITS-1:0] w_dy;
    logic signed [PROD_BITS-1:0] w_p_xc;
    logic signed [PROD_BITS-1:0] w_p_xs;
    logic signed [PROD_BITS-1:0] w_p_yc;
    logic signed [PROD_BITS-1:0] w_p_ys;
    logic [SUM_BITS-1:0]         w_cx_term;
    logic [SUM_BITS-1:0]         w_cy_term;
    logic [SUM_BITS-1:0]         w_sum_x;
    logic [SUM_BITS-1:0]         w_sum_y;

    assign w_dx      = signed'({1'b0, r_s1_px} - {1'b0, r_cx});
    assign w_dy      = signed'({1'b0, r_s1_py} - {1'b0, r_cy});
    assign w_p_xc    = w_dx * r_cos;
    assign w_p_xs    = w_dx * r_sin;
    assign w_p_yc    = w_dy * r_cos;
    assign w_p_ys    = w_dy * r_sin;
    assign w_cx_term = SUM_BITS'({r_cx, {FRAC_BITS{1'b0}}});
    assign w_cy_term = SUM_BITS'({r_cy, {FRAC_BITS{1'b0}}});
    assign w_sum_x   = w_cx_term + SUM_BITS'(w_p_xc) - SUM_BITS'(w_p_ys);
    assign w_sum_y   = w_cy_term + SUM_BITS'(w_p_xs) + SUM_BITS'(w_p_yc);

    // stage 2: fixed-point target
    logic                r_s2_valid;
    logic [1:0]          r_s2_kind;
    logic                r_s2_in_ok;
    logic [DIM_BITS-1:0] r_s2_px;
    logic [DIM_BITS-1:0] r_s2_py;
    logic [PIX_BITS-1:0] r_s2_pix;
    logic [SUM_BITS-1:0] r_s2_sum_x;
    logic [SUM_BITS-1:0] r_s2_sum_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_s2_kind  <= r_s1_kind;
            r_s2_in_ok <= r_s1_in_ok;
            r_s2_px    <= r_s1_px;
            r_s2_py    <= r_s1_py;
            r_s2_pix   <= r_s1_pix;
            r_s2_sum_x <= w_sum_x;
            r_s2_sum_y <= w_sum_y;
        end
    end

    // round to nearest, ties toward zero, on the magnitude
    logic                w_neg_x;
    logic                w_neg_y;
    logic [SUM_BITS-1:0] w_mag_x;
    logic [SUM_BITS-1:0] w_mag_y;
    logic [SUM_BITS-1:0] w_rnd_x;
    logic [SUM_BITS-1:0] w_rnd_y;
    logic [RND_BITS-1:0] w_tx;
    logic [RND_BITS-1:0] w_ty;
    logic                w_tgt_ok;

    assign w_neg_x  = r_s2_sum_x[SUM_BITS-1];
    assign w_neg_y  = r_s2_sum_y[SUM_BITS-1];
    assign w_mag_x  = w_neg_x ? (~r_s2_sum_x + 1'b1) : r_s2_sum_x;
    assign w_mag_y  = w_neg_y ? (~r_s2_sum_y + 1'b1) : r_s2_sum_y;
    assign w_rnd_x  = w_mag_x + SUM_BITS'((1 << (FRAC_BITS - 1)) - 1);
    assign w_rnd_y  = w_mag_y + SUM_BITS'((1 << (FRAC_BITS - 1)) - 1);
    assign w_tx     = w_rnd_x[SUM_BITS-1:FRAC_BITS];
    assign w_ty     = w_rnd_y[SUM_BITS-1:FRAC_BITS];
    // a negative value that rounds to zero is still column/row zero
    assign w_tgt_ok = (!w_neg_x || w_tx == '0) && (!w_neg_y || w_ty == '0)
                      && (w_tx < RND_BITS'(w_eff_w)) && (w_ty < RND_BITS'(w_eff_h));

    logic       w_s2_write;
    logic       w_s2_read;
    logic       w_start_clear;
    t_store_req s_req;

    assign w_s2_write    = r_s2_valid && (r_s2_kind == KIND_WRITE) && r_s2_in_ok && w_tgt_ok;
    assign w_s2_read     = r_s2_valid && (r_s2_kind == KIND_READ) && r_s2_in_ok;
    assign w_start_clear = r_s2_valid && (r_s2_kind == KIND_CLEAR);

    always_comb begin
        s_req.we    = w_s2_write;
        s_req.re    = w_s2_read;
        s_req.wdata = r_s2_pix;
        if (r_s2_kind == KIND_WRITE) begin
            s_req.addr = {w_ty[DIM_BITS-1:0], w_tx[DIM_BITS-1:0]};
        end else begin
            s_req.addr = {r_s2_py, r_s2_px};
        end
    end

    logic [PIX_BITS-1:0] w_rdata;
    logic                w_clearing;

    irnf_store u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start_clear (w_start_clear),
        .i_req         (s_req),
        .o_rdata       (w_rdata),
        .o_clearing    (w_clearing)
    );

    // stage 3: result beat
    logic                r_s3_valid;
    logic                r_s3_rd_ok;
    logic                r_s3_landed;
    logic [DIM_BITS-1:0] r_s3_dx;
    logic [DIM_BITS-1:0] r_s3_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_s3_rd_ok  <= w_s2_read;
            r_s3_landed <= w_s2_write;
            r_s3_dx     <= w_s2_write ? w_tx[DIM_BITS-1:0] : '0;
            r_s3_dy     <= w_s2_write ? w_ty[DIM_BITS-1:0] : '0;
        end
    end

    assign o_strobe           = r_s3_valid;
    assign o_result.pixel_out = r_s3_rd_ok ? w_rdata : '0;
    assign o_result.landed    = r_s3_landed;
    assign o_result.dest_x    = r_s3_dx;
    assign o_result.dest_y    = r_s3_dy;

    // a clear in flight holds off new items until its sweep is done
    assign busy = w_clearing
                  || (r_s1_valid && (r_s1_kind == KIND_CLEAR))
                  || (r_s2_valid && (r_s2_kind == KIND_CLEAR));

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##2 o_strobe)
        else $error("result beat missing three cycles after accept");

    a_sweep_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !s_req.we)
        else $error("pixel write collides with clearing sweep");

    a_landed_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.landed) |->
            (({1'b0, o_result.dest_x} < w_eff_w) && ({1'b0, o_result.dest_y} < w_eff_h)))
        else $error("landed target outside grid");

    a_busy_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> busy)
        else $error("busy low right after reset");
`endif

endmodule
